>>> src/tep_pkg.sv
// Shared types and codes for the tree ensemble predictor.
// Used by the controller, the datapath and the top level.
package tep_pkg;

   // Request kinds carried in req_tuser
   localparam logic [1:0] MODE_NODE = 2'd0;
   localparam logic [1:0] MODE_TREE = 2'd1;
   localparam logic [1:0] MODE_BIN  = 2'd2;
   localparam logic [1:0] MODE_RUN  = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_BIAS         = 2'd0;
   localparam logic [1:0] CSR_TREE_COUNT   = 2'd1;
   localparam logic [1:0] CSR_MISSING_CODE = 2'd2;

   localparam int REQ_DATA_W = 120;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TREE,
      ST_ROOT,
      ST_NODE,
      ST_BIN,
      ST_ACC,
      ST_FIN
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic init_run;
      logic tree_rd;
      logic node_rd_root;
      logic node_rd_child;
      logic bin_rd;
      logic mul;
      logic acc;
      logic mark_bad;
      logic next_tree;
      logic out_load;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic trees_done;
      logic root_bad;
      logic is_leaf;
      logic depth_hit;
      logic child_bad;
      logic out_free;
   } status_type;

endpackage

>>> src/tep_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/tep_ctrl.sv
// Run sequencer for the tree ensemble predictor.
// Depends on tep_pkg for the state, command and status types.
module tep_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic [1:0]          req_mode,
   output logic                req_tready,
   input  tep_pkg::status_type status,
   output tep_pkg::cmd_type    cmd
);
   import tep_pkg::*;

   state_type state_ff, state_in;
   logic      run_start;

   assign req_tready = (state_ff == ST_IDLE);
   assign run_start  = req_tvalid && (req_mode == MODE_RUN);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (run_start) state_in = ST_TREE;
         ST_TREE: state_in = status.trees_done ? ST_FIN : ST_ROOT;
         ST_ROOT: state_in = status.root_bad ? ST_TREE : ST_NODE;
         ST_NODE: begin
            priority if (status.is_leaf) state_in = ST_ACC;
            else if (status.depth_hit)   state_in = ST_TREE;
            else                         state_in = ST_BIN;
         end
         ST_BIN:  state_in = status.child_bad ? ST_TREE : ST_NODE;
         ST_ACC:  state_in = ST_TREE;
         ST_FIN:  if (status.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: cmd.init_run = run_start;
         ST_TREE: cmd.tree_rd = !status.trees_done;
         ST_ROOT: begin
            cmd.mark_bad     = status.root_bad;
            cmd.next_tree    = status.root_bad;
            cmd.node_rd_root = !status.root_bad;
         end
         ST_NODE: begin
            priority if (status.is_leaf) begin
               cmd.mul = 1'b1;
            end else if (status.depth_hit) begin
               cmd.mark_bad  = 1'b1;
               cmd.next_tree = 1'b1;
            end else begin
               cmd.bin_rd = 1'b1;
            end
         end
         ST_BIN: begin
            cmd.mark_bad      = status.child_bad;
            cmd.next_tree     = status.child_bad;
            cmd.node_rd_child = !status.child_bad;
         end
         ST_ACC: begin
            cmd.acc       = 1'b1;
            cmd.next_tree = 1'b1;
         end
         ST_FIN:  cmd.out_load = status.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   // An accumulate always returns to the next tree
   a_acc_then_tree: assert property (@(posedge clock) disable iff (reset)
      cmd.acc |=> state_ff == ST_TREE) else $error("acc not followed by tree");
`endif
endmodule

>>> src/tep_datapath.sv
// Stores, walk registers, scaling multiplier and saturating accumulator.
// Depends on tep_pkg and tep_ram.
module tep_datapath #(
   parameter int NODES     = 1024,
   parameter int TREES     = 64,
   parameter int FEATURES  = 256,
   parameter int MAX_DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_accept,
   input  logic [1:0]          req_mode,
   input  logic [9:0]          req_address,
   input  logic                req_is_leaf,
   input  logic [7:0]          req_split_feature,
   input  logic [7:0]          req_threshold,
   input  logic                req_missing_right,
   input  logic [9:0]          req_left_child,
   input  logic [9:0]          req_right_child,
   input  logic [31:0]         req_leaf_value,
   input  logic [9:0]          req_tree_root,
   input  logic [16:0]         req_learning_rate,
   input  logic [7:0]          req_sample_bin,
   input  logic                csr_we,
   input  logic [1:0]          csr_addr,
   input  logic [31:0]         csr_wdata,
   input  tep_pkg::cmd_type    cmd,
   output tep_pkg::status_type status,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_prediction,
   output logic                rsp_malformed
);
   import tep_pkg::*;

   localparam int NODE_AW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int TREE_AW = (TREES > 1) ? $clog2(TREES) : 1;
   localparam int FEAT_AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int TCW     = $clog2(TREES + 1);
   localparam int SW      = $clog2(MAX_DEPTH + 1);

   // Configuration registers
   logic signed [31:0] bias_ff;
   logic [6:0]         tree_count_ff;
   logic [7:0]         missing_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff         <= '0;
         tree_count_ff   <= '0;
         missing_code_ff <= 8'hFF;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_BIAS:         bias_ff         <= csr_wdata;
            CSR_TREE_COUNT:   tree_count_ff   <= csr_wdata[6:0];
            CSR_MISSING_CODE: missing_code_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Write decode for load requests
   logic [31:0] addr32;
   logic        node_we, tree_we, bin_we;

   assign addr32  = {22'd0, req_address};
   assign node_we = req_accept && (req_mode == MODE_NODE) && (addr32 < NODES);
   assign tree_we = req_accept && (req_mode == MODE_TREE) && (addr32 < TREES);
   assign bin_we  = req_accept && (req_mode == MODE_BIN) && (addr32 < FEATURES);

   // Walk registers
   logic [TCW-1:0]   t_ff, n_ff;
   logic [SW-1:0]    steps_ff;
   logic             bad_ff;
   logic             feat_ok_ff;
   logic signed [31:0] acc_ff;
   logic signed [49:0] prod_ff;

   // Memory read data
   logic [17:0] test_rd;
   logic [19:0] child_rd;
   logic [31:0] value_rd;
   logic [26:0] tree_rd;
   logic [7:0]  bin_rd;

   // Node fields
   logic        nd_leaf, nd_mr;
   logic [7:0]  nd_feat, nd_thr;
   logic [9:0]  nd_left, nd_right;
   logic [9:0]  tr_root;
   logic [16:0] tr_rate;

   assign nd_leaf  = test_rd[17];
   assign nd_feat  = test_rd[16:9];
   assign nd_thr   = test_rd[8:1];
   assign nd_mr    = test_rd[0];
   assign nd_left  = child_rd[19:10];
   assign nd_right = child_rd[9:0];
   assign tr_root  = tree_rd[9:0];
   assign tr_rate  = tree_rd[26:10];

   // Pick the child from the fetched bin
   logic [7:0]  bin_val;
   logic        go_left;
   logic [9:0]  child;
   logic [31:0] child32, root32, feat32, tcnt32;

   assign bin_val = feat_ok_ff ? bin_rd : 8'd0;
   assign go_left = (bin_val == missing_code_ff) ? !nd_mr : (bin_val <= nd_thr);
   assign child   = go_left ? nd_left : nd_right;
   assign child32 = {22'd0, child};
   assign root32  = {22'd0, tr_root};
   assign feat32  = {24'd0, nd_feat};
   assign tcnt32  = {25'd0, tree_count_ff};

   // Node read address: root on entry, child while walking
   logic [NODE_AW-1:0] node_rd_addr;
   logic               node_rd_en;
   logic [31:0]        node_sel32;

   assign node_sel32   = cmd.node_rd_root ? root32 : child32;
   assign node_rd_addr = node_sel32[NODE_AW-1:0];
   assign node_rd_en   = cmd.node_rd_root || cmd.node_rd_child;

   tep_ram #(.WIDTH(18), .DEPTH(NODES)) u_node_test (
      .clock(clock), .wr_en(node_we), .wr_addr(addr32[NODE_AW-1:0]),
      .wr_data({req_is_leaf, req_split_feature, req_threshold, req_missing_right}),
      .rd_en(node_rd_en), .rd_addr(node_rd_addr), .rd_data(test_rd)
   );

   tep_ram #(.WIDTH(20), .DEPTH(NODES)) u_node_child (
      .clock(clock), .wr_en(node_we), .wr_addr(addr32[NODE_AW-1:0]),
      .wr_data({req_left_child, req_right_child}),
      .rd_en(node_rd_en), .rd_addr(node_rd_addr), .rd_data(child_rd)
   );

   tep_ram #(.WIDTH(32), .DEPTH(NODES)) u_node_value (
      .clock(clock), .wr_en(node_we), .wr_addr(addr32[NODE_AW-1:0]),
      .wr_data(req_leaf_value),
      .rd_en(node_rd_en), .rd_addr(node_rd_addr), .rd_data(value_rd)
   );

   tep_ram #(.WIDTH(27), .DEPTH(TREES)) u_tree (
      .clock(clock), .wr_en(tree_we), .wr_addr(addr32[TREE_AW-1:0]),
      .wr_data({req_learning_rate, req_tree_root}),
      .rd_en(cmd.tree_rd), .rd_addr(t_ff[TREE_AW-1:0]), .rd_data(tree_rd)
   );

   tep_ram #(.WIDTH(8), .DEPTH(FEATURES)) u_bins (
      .clock(clock), .wr_en(bin_we), .wr_addr(addr32[FEAT_AW-1:0]),
      .wr_data(req_sample_bin),
      .rd_en(cmd.bin_rd), .rd_addr(feat32[FEAT_AW-1:0]), .rd_data(bin_rd)
   );

   // Scaled term and saturating sum
   logic signed [33:0] term;
   logic signed [34:0] sum;
   logic signed [31:0] sum_sat;

   assign term = prod_ff[49:16];
   assign sum  = 35'(acc_ff) + 35'(term);
   always_comb begin
      priority if (!sum[34] && (sum[33:31] != 3'b000)) sum_sat = 32'sh7FFF_FFFF;
      else if (sum[34] && (sum[33:31] != 3'b111))      sum_sat = 32'sh8000_0000;
      else                                             sum_sat = sum[31:0];
   end

   // Walk control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff     <= '0;
         n_ff     <= '0;
         steps_ff <= '0;
         bad_ff   <= 1'b0;
      end else begin
         if (cmd.init_run) begin
            t_ff   <= '0;
            n_ff   <= (tcnt32 < TREES) ? tcnt32[TCW-1:0] : TCW'(TREES);
            bad_ff <= 1'b0;
         end else begin
            if (cmd.next_tree) t_ff <= t_ff + TCW'(1);
            if (cmd.mark_bad)  bad_ff <= 1'b1;
         end
         if (cmd.node_rd_root) begin
            steps_ff <= '0;
         end else if (cmd.node_rd_child) begin
            steps_ff <= steps_ff + SW'(1);
         end
      end
   end

   // Payload registers: feature flag, product, accumulator
   always_ff @(posedge clock) begin
      if (cmd.bin_rd) feat_ok_ff <= (feat32 < FEATURES);
      if (cmd.mul)    prod_ff <= $signed(value_rd) * $signed({1'b0, tr_rate});
      if (cmd.init_run) begin
         acc_ff <= bias_ff;
      end else if (cmd.acc) begin
         acc_ff <= sum_sat;
      end
   end

   // Output register
   logic        rsp_valid_ff;
   logic [31:0] rsp_pred_ff;
   logic        rsp_bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_pred_ff <= acc_ff;
         rsp_bad_ff  <= bad_ff;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_prediction = rsp_pred_ff;
   assign rsp_malformed  = rsp_bad_ff;

   // Status to controller
   assign status.trees_done = (t_ff == n_ff);
   assign status.root_bad   = (root32 >= NODES);
   assign status.is_leaf    = nd_leaf;
   assign status.depth_hit  = (steps_ff >= SW'(MAX_DEPTH));
   assign status.child_bad  = (child32 >= NODES);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

`ifndef SYNTH
   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= SW'(MAX_DEPTH)) else $error("walk step count past bound");
   a_tree_bound: assert property (@(posedge clock) disable iff (reset)
      t_ff <= n_ff) else $error("tree index past tree count");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.out_load)) else $error("result without load");
`endif
endmodule

>>> src/tree_ensemble_predictor_top.sv
// Tree ensemble predictor top level: controller plus datapath.
// Depends on tep_pkg, tep_ctrl, tep_datapath and tep_ram.
//
// Load requests (node, tree, sample bin) are taken while idle and give no
// result. A run request gives one result: the saturated Q16.16 sum of the bias
// register and rate-scaled leaf values, with a flag if any walk broke. Each node
// visit costs a node-memory read and a sample-bin read in turn. A tree that hits
// the depth bound stops there. No request is taken while a run is in progress; a
// finished result waits in the output register while loads continue.
module tree_ensemble_predictor_top #(
   parameter int NODES     = 1024,
   parameter int TREES     = 64,
   parameter int FEATURES  = 256,
   parameter int MAX_DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // address[9:0] is_leaf[10] split_feature[18:11] threshold[26:19]
   // missing_right[27] left_child[37:28] right_child[47:38] leaf_value[79:48]
   // tree_root[89:80] learning_rate[106:90] sample_bin[114:107] zero[119:115]
   input  logic [tep_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // prediction[31:0]
   output logic [31:0]                    rsp_tdata,
   // malformed[0]
   output logic                           rsp_tuser,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_addr,
   input  logic [31:0]                    csr_wdata
);
   import tep_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_accept;

   assign req_accept = req_tvalid && req_tready;

   tep_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_mode(req_tuser), .req_tready(req_tready),
      .status(status), .cmd(cmd)
   );

   tep_datapath #(
      .NODES(NODES), .TREES(TREES), .FEATURES(FEATURES), .MAX_DEPTH(MAX_DEPTH)
   ) u_datapath (
      .clock(clock), .reset(reset),
      .req_accept(req_accept), .req_mode(req_tuser),
      .req_address(req_tdata[9:0]),
      .req_is_leaf(req_tdata[10]),
      .req_split_feature(req_tdata[18:11]),
      .req_threshold(req_tdata[26:19]),
      .req_missing_right(req_tdata[27]),
      .req_left_child(req_tdata[37:28]),
      .req_right_child(req_tdata[47:38]),
      .req_leaf_value(req_tdata[79:48]),
      .req_tree_root(req_tdata[89:80]),
      .req_learning_rate(req_tdata[106:90]),
      .req_sample_bin(req_tdata[114:107]),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .cmd(cmd), .status(status),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_prediction(rsp_tdata), .rsp_malformed(rsp_tuser)
   );
endmodule
